// ===== rtl/mmpw_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpw_pkg
// Shared types and constants for the modular matrix power walk counter.
// ----------------------------------------------------------------------------
`default_nettype none
package mmpw_pkg;

  localparam int MMPW_MAX_NODES = 128;
  localparam int MMPW_DW        = 30;
  localparam logic [MMPW_DW-1:0] MMPW_MOD = 30'd1000000009;
  // floor(2^61 / modulus)
  localparam logic [31:0] MMPW_BARRETT = 32'd2305842988;

  localparam logic [1:0] REG_NODES  = 2'd0;
  localparam logic [1:0] REG_SOURCE = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;
  localparam logic [1:0] REG_LENGTH = 2'd3;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_COMPUTE  = 1'b1;

  typedef struct packed {
    logic [7:0]  nodes;
    logic [7:0]  source;
    logic [7:0]  target;
    logic [62:0] length;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic mul_vld;
    logic red_start;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/mmpw_if.sv =====
// ----------------------------------------------------------------------------
// mmpw_in_if / mmpw_out_if
// Valid/ready channels for command words and walk count words.
// ----------------------------------------------------------------------------
`default_nettype none
interface mmpw_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] node_a;
  logic [7:0] node_b;
  modport source (output valid, output op, output node_a, output node_b, input ready);
  modport sink   (input valid, input op, input node_a, input node_b, output ready);
endinterface

interface mmpw_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] walk_count;
  modport source (output valid, output walk_count, input ready);
  modport sink   (input valid, input walk_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/mmpw_cfg.sv =====
// ----------------------------------------------------------------------------
// mmpw_cfg
// APB-style register file: node count, source, target, walk length.
// ----------------------------------------------------------------------------
`default_nettype none
module mmpw_cfg
  import mmpw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[4:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nodes  <= 8'd1;
      cfg_r.source <= 8'd1;
      cfg_r.target <= 8'd1;
      cfg_r.length <= '0;
    end else if (wr) begin
      case (idx)
        REG_NODES:  cfg_r.nodes  <= pwdata[7:0];
        REG_SOURCE: cfg_r.source <= pwdata[7:0];
        REG_TARGET: cfg_r.target <= pwdata[7:0];
        REG_LENGTH: cfg_r.length <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NODES:  prdata = {56'd0, cfg_r.nodes};
      REG_SOURCE: prdata = {56'd0, cfg_r.source};
      REG_TARGET: prdata = {56'd0, cfg_r.target};
      REG_LENGTH: prdata = {1'b0, cfg_r.length};
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mmpw_mac.sv =====
// ----------------------------------------------------------------------------
// mmpw_mac
// Shared multiply-accumulate; each product is reduced modulo the prime by a
// pipelined Barrett estimate and added into a reduced accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module mmpw_mac
  import mmpw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mac_ctl_t           ctl,
  input  wire logic [MMPW_DW-1:0] x,
  input  wire logic [MMPW_DW-1:0] y,
  output logic [MMPW_DW-1:0]      res,
  output logic                    done
);

  logic [2*MMPW_DW-1:0] prod_r;
  logic                 pv_r;
  logic [62:0]          qm_r;
  logic [31:0]          lo_r;
  logic                 qv_r;
  logic [31:0]          rem_r;
  logic                 rv_r;
  logic [MMPW_DW-1:0]   red_r;
  logic                 dv_r;
  logic [MMPW_DW-1:0]   acc_r;
  logic                 busy_r;
  logic [30:0]          q;
  logic [31:0]          qp;
  logic [31:0]          rem_sub;
  logic [MMPW_DW:0]     sum;
  logic                 pipe_busy;

  // quotient estimate is at most one short, so one subtract finishes
  assign q         = qm_r[62:32];
  assign qp        = 32'(q) * 32'(MMPW_MOD);
  assign rem_sub   = rem_r - 32'(MMPW_MOD);
  assign sum       = {1'b0, acc_r} + {1'b0, red_r};
  assign pipe_busy = ctl.mul_vld | pv_r | qv_r | rv_r | dv_r;
  assign res       = acc_r;
  assign done      = busy_r & ~pipe_busy;

  always_ff @(posedge clk) begin
    prod_r <= (2*MMPW_DW)'(x) * (2*MMPW_DW)'(y);
    qm_r   <= 63'(prod_r[59:29]) * 63'(MMPW_BARRETT);
    lo_r   <= prod_r[31:0];
    rem_r  <= lo_r - qp;
    red_r  <= (rem_r >= 32'(MMPW_MOD)) ? rem_sub[MMPW_DW-1:0] : rem_r[MMPW_DW-1:0];
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (dv_r) begin
      acc_r <= (sum >= {1'b0, MMPW_MOD}) ? MMPW_DW'(sum - {1'b0, MMPW_MOD}) :
                                           sum[MMPW_DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      qv_r   <= 1'b0;
      rv_r   <= 1'b0;
      dv_r   <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul_vld;
      qv_r <= pv_r;
      rv_r <= qv_r;
      dv_r <= rv_r;
      if (ctl.red_start) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/modular_matrix_power_walk_count.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_power_walk_count
// Walk counter: adjacency matrix raised to a power modulo 1000000009.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    op, node_a, node_b
//   out_ch    out   valid/ready    walk_count
//   cfg_*     in    APB write/read nodes, source, target, walk length
//
// Edge word: read, increment and write back both symmetric entries. Compute
// word: n*n identity fill, then per exponent step a bit test and a product
// through the one shared MAC (four-stage modular pipeline drained per entry)
// and an n*n copy; then a full adjacency clear of all 2^(2*log2 MAX) entries.
// The same clear runs after reset. Not ready while busy; the result register
// holds a word while a stalled sink waits.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_matrix_power_walk_count
  import mmpw_pkg::*;
#(
  parameter int MAX_NODES = MMPW_MAX_NODES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mmpw_in_if.sink          in_ch,
  mmpw_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NIW   = $clog2(MAX_NODES);
  localparam int AW    = 2 * NIW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int CW    = (NW > 8) ? NW : 8;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_E_RD0 = 5'd1;
  localparam logic [4:0] ST_E_WR0 = 5'd2;
  localparam logic [4:0] ST_E_RD1 = 5'd3;
  localparam logic [4:0] ST_E_WR1 = 5'd4;
  localparam logic [4:0] ST_INIT  = 5'd5;
  localparam logic [4:0] ST_BIT   = 5'd6;
  localparam logic [4:0] ST_MAC   = 5'd7;
  localparam logic [4:0] ST_MD1   = 5'd8;
  localparam logic [4:0] ST_MD2   = 5'd9;
  localparam logic [4:0] ST_RST   = 5'd10;
  localparam logic [4:0] ST_RWAIT = 5'd11;
  localparam logic [4:0] ST_CP_RD = 5'd12;
  localparam logic [4:0] ST_CP_WR = 5'd13;
  localparam logic [4:0] ST_RES   = 5'd14;
  localparam logic [4:0] ST_RES2  = 5'd15;
  localparam logic [4:0] ST_EMIT  = 5'd16;
  localparam logic [4:0] ST_CLR   = 5'd17;

  cfg_t cfg;

  mmpw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  logic [MMPW_DW-1:0] mem_a [DEPTH];
  logic [MMPW_DW-1:0] mem_p [DEPTH];
  logic [MMPW_DW-1:0] mem_s [DEPTH];

  logic [4:0]         st_r, st_nxt;
  logic [NIW-1:0]     i_r, i_nxt, j_r, j_nxt, kk_r, kk_nxt;
  logic [AW-1:0]      ia_r, ia_nxt, ib_r, ib_nxt, clr_r, clr_nxt;
  logic [62:0]        k_r, k_nxt;
  logic               mode_r, mode_nxt;
  logic [MMPW_DW-1:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MMPW_DW-1:0] out_data_r, out_data_nxt;
  logic               rd_pend_r;

  logic [NW-1:0]      n_use;
  logic [NIW-1:0]     nl;
  logic               a_ok, b_ok, st_ok;
  logic [NIW-1:0]     a_ix, b_ix, s_ix, t_ix;
  logic               last_j, last_i, last_k;

  logic [AW-1:0]      a_ra1, a_ra2, p_ra, s_ra, a_wa, p_wa, s_wa;
  logic [MMPW_DW-1:0] a_rd1, a_rd2, p_rd, s_rd, a_wd, p_wd, a_inc;
  logic               a_we, p_we, s_we;

  mac_ctl_t           mac_ctl;
  logic [MMPW_DW-1:0] mac_x, mac_res;
  logic               mac_done;

  assign n_use = (CW'(cfg.nodes) > CW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(cfg.nodes);
  assign nl    = NIW'(n_use - NW'(1));
  assign a_ok  = (in_ch.node_a != 8'd0) && (CW'(in_ch.node_a) <= CW'(n_use));
  assign b_ok  = (in_ch.node_b != 8'd0) && (CW'(in_ch.node_b) <= CW'(n_use));
  assign st_ok = (cfg.source != 8'd0) && (CW'(cfg.source) <= CW'(n_use)) &&
                 (cfg.target != 8'd0) && (CW'(cfg.target) <= CW'(n_use));
  assign a_ix  = NIW'(in_ch.node_a - 8'd1);
  assign b_ix  = NIW'(in_ch.node_b - 8'd1);
  assign s_ix  = NIW'(cfg.source - 8'd1);
  assign t_ix  = NIW'(cfg.target - 8'd1);
  assign last_j = (j_r == nl);
  assign last_i = (i_r == nl);
  assign last_k = (kk_r == nl);

  assign in_ch.ready       = (st_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.walk_count = out_data_r;

  // memory ports
  assign a_ra1 = (st_r == ST_E_RD0 || st_r == ST_E_WR0) ? ia_r :
                 (st_r == ST_E_RD1 || st_r == ST_E_WR1) ? ib_r : {i_r, kk_r};
  assign a_ra2 = {kk_r, j_r};
  assign p_ra  = (st_r == ST_RES) ? {s_ix, t_ix} : {i_r, kk_r};
  assign s_ra  = {i_r, j_r};
  assign a_inc = ((a_rd1 + 1'b1) >= MMPW_MOD) ? (a_rd1 + 1'b1 - MMPW_MOD) : (a_rd1 + 1'b1);

  always_comb begin
    a_we = 1'b0;
    a_wa = {i_r, j_r};
    a_wd = s_rd;
    p_we = 1'b0;
    p_wa = {i_r, j_r};
    p_wd = s_rd;
    case (st_r)
      ST_E_WR0: begin
        a_we = 1'b1;
        a_wa = ia_r;
        a_wd = a_inc;
      end
      ST_E_WR1: begin
        a_we = 1'b1;
        a_wa = ib_r;
        a_wd = a_inc;
      end
      ST_CLR: begin
        a_we = 1'b1;
        a_wa = clr_r;
        a_wd = '0;
      end
      ST_CP_WR: begin
        a_we = !mode_r;
        p_we = mode_r;
      end
      ST_INIT: begin
        p_we = 1'b1;
        p_wd = (i_r == j_r) ? MMPW_DW'(1) : '0;
      end
      default: ;
    endcase
  end

  assign s_we = (st_r == ST_RWAIT) && mac_done;
  assign s_wa = {i_r, j_r};

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_wa] <= a_wd;
    a_rd1 <= mem_a[a_ra1];
    a_rd2 <= mem_a[a_ra2];
  end

  always_ff @(posedge clk) begin
    if (p_we) mem_p[p_wa] <= p_wd;
    p_rd <= mem_p[p_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) mem_s[s_wa] <= mac_res;
    s_rd <= mem_s[s_ra];
  end

  // shared multiply-accumulate
  assign mac_x             = mode_r ? p_rd : a_rd1;
  assign mac_ctl.clear     = (st_r == ST_BIT) || s_we;
  assign mac_ctl.mul_vld   = rd_pend_r;
  assign mac_ctl.red_start = (st_r == ST_RST);

  mmpw_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .x     (mac_x),
    .y     (a_rd2),
    .res   (mac_res),
    .done  (mac_done)
  );

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kk_nxt        = kk_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    mode_nxt      = mode_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op == OP_ADD_EDGE) begin
            ia_nxt = {a_ix, b_ix};
            ib_nxt = {b_ix, a_ix};
            if (a_ok && b_ok) st_nxt = ST_E_RD0;
          end else if (n_use == '0) begin
            res_nxt = '0;
            st_nxt  = ST_EMIT;
          end else begin
            i_nxt  = '0;
            j_nxt  = '0;
            k_nxt  = cfg.length;
            st_nxt = ST_INIT;
          end
        end
      end
      ST_E_RD0: st_nxt = ST_E_WR0;
      ST_E_WR0: st_nxt = ST_E_RD1;
      ST_E_RD1: st_nxt = ST_E_WR1;
      ST_E_WR1: st_nxt = ST_IDLE;
      ST_INIT: begin
        j_nxt = last_j ? '0 : j_r + 1'b1;
        if (last_j) i_nxt = i_r + 1'b1;
        if (last_j && last_i) begin
          i_nxt  = '0;
          st_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        i_nxt  = '0;
        j_nxt  = '0;
        kk_nxt = '0;
        if (k_r == '0) begin
          st_nxt = ST_RES;
        end else if (k_r[0]) begin
          k_nxt    = {k_r[62:1], 1'b0};
          mode_nxt = 1'b1;
          st_nxt   = ST_MAC;
        end else begin
          k_nxt    = k_r >> 1;
          mode_nxt = 1'b0;
          st_nxt   = ST_MAC;
        end
      end
      ST_MAC: begin
        kk_nxt = kk_r + 1'b1;
        if (last_k) st_nxt = ST_MD1;
      end
      ST_MD1: st_nxt = ST_MD2;
      ST_MD2: st_nxt = ST_RST;
      ST_RST: st_nxt = ST_RWAIT;
      ST_RWAIT: begin
        if (mac_done) begin
          kk_nxt = '0;
          j_nxt  = last_j ? '0 : j_r + 1'b1;
          if (last_j) i_nxt = i_r + 1'b1;
          st_nxt = ST_MAC;
          if (last_j && last_i) begin
            i_nxt  = '0;
            st_nxt = ST_CP_RD;
          end
        end
      end
      ST_CP_RD: st_nxt = ST_CP_WR;
      ST_CP_WR: begin
        j_nxt  = last_j ? '0 : j_r + 1'b1;
        if (last_j) i_nxt = i_r + 1'b1;
        st_nxt = ST_CP_RD;
        if (last_j && last_i) st_nxt = ST_BIT;
      end
      ST_RES:  st_nxt = ST_RES2;
      ST_RES2: begin
        res_nxt = st_ok ? p_rd : '0;
        st_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          clr_nxt       = '0;
          st_nxt        = ST_CLR;
        end
      end
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= (st_r == ST_MAC);
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    kk_r       <= kk_nxt;
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    k_r        <= k_nxt;
    mode_r     <= mode_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_emit_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_EMIT)
    else $error("result word raised outside emit");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> st_r == ST_RWAIT)
    else $error("reduction finished outside wait state");
  a_exp_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BIT && k_r != '0) |=> k_r < $past(k_r))
    else $error("exponent did not shrink");
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_COMPUTE) |=> !in_ch.ready)
    else $error("ready during compute");
`endif

endmodule
`default_nettype wire

// ===== sim/modular_matrix_power_walk_count_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_matrix_power_walk_count_test
// Loads random multigraphs edge by edge, raises them to configured powers
// and checks each emitted walk count against a matrix-power scoreboard.
// Runs directed corner graphs first, then random graphs under mixed stalls.
// ----------------------------------------------------------------------------
module modular_matrix_power_walk_count_test;
  import mmpw_pkg::*;

  localparam longint unsigned PRIME = longint'(MMPW_MOD);
  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int WORD_TARGET = 1800;

  class walk_scoreboard;
    int unsigned adj[MMPW_MAX_NODES][MMPW_MAX_NODES];
    int unsigned pw[MMPW_MAX_NODES][MMPW_MAX_NODES];
    int unsigned tmp[MMPW_MAX_NODES][MMPW_MAX_NODES];
    logic [7:0]  nodes;
    logic [7:0]  src;
    logic [7:0]  tgt;
    logic [62:0] len;
    logic [29:0] expected_counts[$];
    int errors;

    function new();
      nodes = 1;
      src = 1;
      tgt = 1;
      len = '0;
      errors = 0;
      foreach (adj[i, j]) adj[i][j] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_NODES:  nodes = value[7:0];
        REG_SOURCE: src = value[7:0];
        REG_TARGET: tgt = value[7:0];
        REG_LENGTH: len = value[62:0];
        default: ;
      endcase
    endfunction

    // square: adj = adj*adj, else pw = pw*adj
    function void product(bit square, int n);
      longint unsigned acc;
      longint unsigned x;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++) begin
            x = square ? adj[i][k] : pw[i][k];
            acc = (acc + x * longint'(adj[k][j])) % PRIME;
          end
          tmp[i][j] = int'(acc);
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          if (square) adj[i][j] = tmp[i][j];
          else pw[i][j] = tmp[i][j];
    endfunction

    function void note_word(logic op, logic [7:0] a, logic [7:0] b);
      int n;
      logic [62:0] k;
      logic [29:0] count;
      n = (nodes > MMPW_MAX_NODES) ? MMPW_MAX_NODES : nodes;
      if (op == OP_ADD_EDGE) begin
        if (a < 1 || a > n || b < 1 || b > n) return;
        adj[a-1][b-1] = (adj[a-1][b-1] + 1 >= PRIME) ? 0 : adj[a-1][b-1] + 1;
        adj[b-1][a-1] = (adj[b-1][a-1] + 1 >= PRIME) ? 0 : adj[b-1][a-1] + 1;
        return;
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          pw[i][j] = (i == j) ? 1 : 0;
      k = len;
      while (k != 0) begin
        if (k[0]) product(1'b0, n);
        k = k >> 1;
        if (k != 0) product(1'b1, n);
      end
      count = '0;
      if (src >= 1 && src <= n && tgt >= 1 && tgt <= n) count = pw[src-1][tgt-1];
      expected_counts.push_back(count);
      foreach (adj[i, j]) adj[i][j] = 0;
    endfunction

    function void check_count(logic [29:0] got);
      logic [29:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: walk_count expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
        $display("%0t: walk_count expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          words_sent;
  int          cycles = 0;

  mmpw_in_if  in_ch ();
  mmpw_out_if out_ch ();

  walk_scoreboard sb = new();

  modular_matrix_power_walk_count u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** modular_matrix_power_walk_count: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_count(out_ch.walk_count);
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once nothing is owed and ready has held for a while
  task automatic wait_idle();
    int quiet;
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    quiet = 0;
    while (quiet < 16) begin
      @(posedge clk);
      quiet = in_ch.ready ? quiet + 1 : 0;
    end
  endtask

  task automatic configure(logic [7:0] nodes, logic [7:0] src, logic [7:0] tgt,
                           logic [62:0] len);
    wait_idle();
    cfg_write(REG_NODES, {56'd0, nodes});
    cfg_write(REG_SOURCE, {56'd0, src});
    cfg_write(REG_TARGET, {56'd0, tgt});
    cfg_write(REG_LENGTH, {1'b0, len});
  endtask

  task automatic send_word(logic op, logic [7:0] a, logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(op, a, b);
    words_sent++;
  endtask

  function automatic logic [62:0] pick_length(int n);
    logic [63:0] wide;
    int r;
    wide = {$urandom, $urandom};
    r = $urandom_range(99);
    if (n > 24) return '0;
    if (n > 6) return 63'($urandom_range(1));
    if (r < 50) return 63'($urandom_range(15));
    if (r < 80) return (n <= 4) ? 63'(wide[15:0]) : 63'($urandom_range(255));
    if (n > 2) return 63'($urandom_range(255));
    if (r < 85) return {63{1'b1}};
    return wide[62:0];
  endfunction

  function automatic logic [7:0] pick_vertex(int n);
    if (n >= 1 && $urandom_range(99) < 88) return 8'($urandom_range(n, 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic random_edges(int n, int count);
    for (int e = 0; e < count; e++) send_word(OP_ADD_EDGE, pick_vertex(n), pick_vertex(n));
  endtask

  initial begin
    int r;
    int n;
    int mode;
    logic [7:0] nodes;
    rst_n = 1'b0;
    words_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD_EDGE;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // reset settings: one vertex, length zero
    send_word(OP_COMPUTE, 8'd0, 8'd0);
    // path with self-loop, multi-edge and out-of-range endpoints
    configure(8'd4, 8'd1, 8'd4, 63'd3);
    send_word(OP_ADD_EDGE, 8'd1, 8'd2);
    send_word(OP_ADD_EDGE, 8'd2, 8'd3);
    send_word(OP_ADD_EDGE, 8'd3, 8'd4);
    send_word(OP_ADD_EDGE, 8'd4, 8'd4);
    send_word(OP_ADD_EDGE, 8'd2, 8'd1);
    send_word(OP_ADD_EDGE, 8'd0, 8'd1);
    send_word(OP_ADD_EDGE, 8'd5, 8'd2);
    send_word(OP_ADD_EDGE, 8'd255, 8'd255);
    send_word(OP_COMPUTE, 8'd255, 8'd255);
    // longest exponent
    configure(8'd2, 8'd2, 8'd1, {63{1'b1}});
    send_word(OP_ADD_EDGE, 8'd1, 8'd2);
    send_word(OP_ADD_EDGE, 8'd2, 8'd2);
    send_word(OP_COMPUTE, 8'd0, 8'd0);
    // no vertices at all
    configure(8'd0, 8'd1, 8'd1, 63'd2);
    send_word(OP_ADD_EDGE, 8'd1, 8'd1);
    send_word(OP_COMPUTE, 8'd1, 8'd1);
    // count above the maximum, top vertex
    configure(8'd200, 8'd128, 8'd128, 63'd0);
    send_word(OP_ADD_EDGE, 8'd128, 8'd128);
    send_word(OP_ADD_EDGE, 8'd129, 8'd1);
    send_word(OP_COMPUTE, 8'd0, 8'd0);
    // source out of range, then leftovers beyond a shrunk node count
    configure(8'd10, 8'd0, 8'd2, 63'd5);
    send_word(OP_ADD_EDGE, 8'd9, 8'd10);
    send_word(OP_ADD_EDGE, 8'd1, 8'd2);
    send_word(OP_COMPUTE, 8'd0, 8'd0);
    configure(8'd10, 8'd1, 8'd1, 63'd2);
    send_word(OP_ADD_EDGE, 8'd2, 8'd10);
    send_word(OP_ADD_EDGE, 8'd1, 8'd2);
    configure(8'd2, 8'd1, 8'd1, 63'd2);
    send_word(OP_COMPUTE, 8'd0, 8'd0);

    while (words_sent < WORD_TARGET) begin
      mode = $urandom_range(3);
      r = $urandom_range(99);
      if (r < 70) nodes = 8'($urandom_range(5, 1));
      else if (r < 80) nodes = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, 129));
      else nodes = 8'($urandom_range(128, 6));
      n = (nodes > MMPW_MAX_NODES) ? MMPW_MAX_NODES : nodes;
      if ($urandom_range(99) < 15) begin
        configure(8'($urandom_range(20, 6)), pick_vertex(n), pick_vertex(n), '0);
        random_edges(20, $urandom_range(12, 2));
      end
      configure(nodes, pick_vertex(n), pick_vertex(n), pick_length(n));
      send_idle_pct  = (mode == 1) ? 68 : (mode == 3) ? 6 : 0;
      recv_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 6 : 0;
      random_edges(n, $urandom_range(60, 10));
      send_word(OP_COMPUTE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct = 0;
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** modular_matrix_power_walk_count: PASSED **");
    end else begin
      $display("** modular_matrix_power_walk_count: FAILED **");
    end
    $finish;
  end

endmodule
